// ----- rtl/smallest_free_id_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the lowest free identifier allocator
// Same-cycle and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SMALLEST_FREE_ID_ALLOCATOR_ASSERT_SVH
`define SMALLEST_FREE_ID_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfa: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfa: next-cycle check failed");

`endif

// ----- rtl/sfa_pkg.sv -----
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared types, codes and helpers for the lowest free identifier allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfa_pkg;

    localparam int WORD_W   = 32;   // bits per bitmap row
    localparam int WORD_LOG = 5;
    localparam int SEAT_W   = 11;
    localparam int DATA_W   = 16;   // stream tdata width
    localparam int STATUS_W = 2;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [0:0] {
        OP_RESERVE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_BAD_RELEASE = 2'd2
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [SEAT_W-1:0] seat;
    } t_item;

    typedef struct packed {
        logic [SEAT_W-1:0] granted;
        t_status           status;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MID,
        S_LEAF,
        S_REL,
        S_DONE
    } t_state;

    // Index of the lowest clear bit; only meaningful when one exists.
    function automatic logic [WORD_LOG-1:0] lowest_zero(input t_word w);
        logic [WORD_LOG-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                idx = WORD_LOG'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/sfa_ram.sv -----
// ----------------------------------------------------------------------------
// sfa_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfa_ctrl
// Sequencer: clearing sweep, summary-to-leaf search and read-modify-write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfa_ctrl #(
    parameter int MAX_SEATS = 1024,
    parameter int ROW_AW    = 5,
    parameter int MID_AW    = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  sfa_pkg::t_item               i_item,
    input  logic [sfa_pkg::SEAT_W-1:0]   i_count,
    input  logic                         i_out_free,
    output logic                         o_ready,
    output logic                         o_res_valid,
    output sfa_pkg::t_result             o_res,
    // leaf bitmap RAM
    output logic                         o_leaf_re,
    output logic [ROW_AW-1:0]            o_leaf_raddr,
    input  sfa_pkg::t_word               i_leaf_rdata,
    output logic                         o_leaf_we,
    output logic [ROW_AW-1:0]            o_leaf_waddr,
    output sfa_pkg::t_word               o_leaf_wdata,
    // summary (row-full) RAM
    output logic                         o_mid_re,
    output logic [MID_AW-1:0]            o_mid_raddr,
    input  sfa_pkg::t_word               i_mid_rdata,
    output logic                         o_mid_we,
    output logic [MID_AW-1:0]            o_mid_waddr,
    output sfa_pkg::t_word               o_mid_wdata
);

    localparam int ROWS   = (MAX_SEATS + sfa_pkg::WORD_W - 1) / sfa_pkg::WORD_W;
    localparam int MROWS  = (ROWS + sfa_pkg::WORD_W - 1) / sfa_pkg::WORD_W;
    localparam int WL     = sfa_pkg::WORD_LOG;
    localparam int SW     = sfa_pkg::SEAT_W;

    // Bits past the end of the last row / last summary row read as taken.
    localparam int          LAST_VALID  = MAX_SEATS - (ROWS - 1) * sfa_pkg::WORD_W;
    localparam logic [63:0] LAST_ONES   = (64'd1 << LAST_VALID) - 64'd1;
    localparam logic [31:0] LAST_PAD    = ~LAST_ONES[31:0];
    localparam int          MLAST_VALID = ROWS - (MROWS - 1) * sfa_pkg::WORD_W;
    localparam logic [63:0] MLAST_ONES  = (64'd1 << MLAST_VALID) - 64'd1;
    localparam logic [31:0] MLAST_PAD   = ~MLAST_ONES[31:0];

    sfa_pkg::t_state  r_state, n_state;
    logic [ROW_AW-1:0] r_clr, n_clr;
    logic [MROWS-1:0]  r_top, n_top;
    logic [MID_AW-1:0] r_mid_addr, n_mid_addr;
    logic [ROW_AW-1:0] r_row, n_row;
    logic [WL-1:0]     r_bit, n_bit;
    sfa_pkg::t_word    r_mid_word, n_mid_word;
    sfa_pkg::t_result  r_res, n_res;

    // summary flops search
    logic              top_full;
    logic [MID_AW-1:0] top_sel;

    // release decode
    logic              rel_in_range;
    logic [SW-1:0]     rel_idx;
    logic [31:0]       rel32;

    // search datapath
    logic [31:0]       clr32, mid_addr32, row32, mid_row32, grant32;
    sfa_pkg::t_word    mid_pad, leaf_pad, mid_word_m, leaf_word_m;
    sfa_pkg::t_word    leaf_one, row_one, rel_one, leaf_set, mid_set;
    logic [WL-1:0]     mid_sel, leaf_sel;
    logic              leaf_now_full, mid_now_full, rel_taken;

    always_comb begin
        top_sel = '0;
        for (int i = MROWS - 1; i >= 0; i--) begin
            if (!r_top[i]) begin
                top_sel = MID_AW'(i);
            end
        end
    end

    assign top_full     = &r_top;
    assign rel_in_range = (i_item.seat != '0) && (i_item.seat <= i_count);
    assign rel_idx      = i_item.seat - SW'(1);
    assign rel32        = 32'(rel_idx);

    assign clr32      = 32'(r_clr);
    assign mid_addr32 = 32'(r_mid_addr);
    assign row32      = 32'(r_row);

    assign mid_pad     = (mid_addr32 == 32'(MROWS - 1)) ? MLAST_PAD : '0;
    assign leaf_pad    = (row32 == 32'(ROWS - 1)) ? LAST_PAD : '0;
    assign mid_word_m  = i_mid_rdata | mid_pad;
    assign leaf_word_m = i_leaf_rdata | leaf_pad;
    assign mid_sel     = sfa_pkg::lowest_zero(mid_word_m);
    assign leaf_sel    = sfa_pkg::lowest_zero(leaf_word_m);
    assign mid_row32   = (mid_addr32 << WL) | 32'(mid_sel);
    assign grant32     = (row32 << WL) | 32'(leaf_sel);

    assign leaf_one      = 32'd1 << leaf_sel;
    assign row_one       = 32'd1 << row32[WL-1:0];
    assign rel_one       = 32'd1 << r_bit;
    assign leaf_set      = leaf_word_m | leaf_one;
    assign mid_set       = r_mid_word | row_one;
    assign leaf_now_full = &leaf_set;
    assign mid_now_full  = &mid_set;
    assign rel_taken     = |(i_leaf_rdata & rel_one);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfa_pkg::S_CLEAR: begin
                if (clr32 == 32'(ROWS - 1)) begin
                    n_state = sfa_pkg::S_IDLE;
                end
            end
            sfa_pkg::S_IDLE: begin
                if (i_start) begin
                    if (i_item.op == sfa_pkg::OP_RESERVE) begin
                        n_state = top_full ? sfa_pkg::S_DONE : sfa_pkg::S_MID;
                    end else begin
                        n_state = rel_in_range ? sfa_pkg::S_REL : sfa_pkg::S_DONE;
                    end
                end
            end
            sfa_pkg::S_MID:  n_state = sfa_pkg::S_LEAF;
            sfa_pkg::S_LEAF: n_state = sfa_pkg::S_DONE;
            sfa_pkg::S_REL:  n_state = sfa_pkg::S_DONE;
            sfa_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = sfa_pkg::S_IDLE;
                end
            end
            default: n_state = sfa_pkg::S_CLEAR;
        endcase
    end

    // memory accesses and working registers
    always_comb begin
        n_clr        = r_clr;
        n_top        = r_top;
        n_mid_addr   = r_mid_addr;
        n_row        = r_row;
        n_bit        = r_bit;
        n_mid_word   = r_mid_word;
        n_res        = r_res;
        o_leaf_re    = 1'b0;
        o_leaf_raddr = r_row;
        o_leaf_we    = 1'b0;
        o_leaf_waddr = r_row;
        o_leaf_wdata = '0;
        o_mid_re     = 1'b0;
        o_mid_raddr  = r_mid_addr;
        o_mid_we     = 1'b0;
        o_mid_waddr  = r_mid_addr;
        o_mid_wdata  = '0;
        case (r_state)
            sfa_pkg::S_CLEAR: begin
                o_leaf_we    = 1'b1;
                o_leaf_waddr = r_clr;
                o_mid_we     = (clr32 < 32'(MROWS));
                o_mid_waddr  = clr32[MID_AW-1:0];
                n_clr        = r_clr + ROW_AW'(1);
            end
            sfa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_res.granted = '0;
                    if (i_item.op == sfa_pkg::OP_RESERVE) begin
                        n_res.status = sfa_pkg::ST_FULL;
                        o_mid_re     = !top_full;
                        o_mid_raddr  = top_sel;
                        n_mid_addr   = top_sel;
                    end else begin
                        n_res.status = sfa_pkg::ST_BAD_RELEASE;
                        o_leaf_re    = rel_in_range;
                        o_leaf_raddr = rel32[ROW_AW+WL-1:WL];
                        o_mid_re     = rel_in_range;
                        o_mid_raddr  = rel32[MID_AW+2*WL-1:2*WL];
                        n_row        = rel32[ROW_AW+WL-1:WL];
                        n_bit        = rel32[WL-1:0];
                        n_mid_addr   = rel32[MID_AW+2*WL-1:2*WL];
                    end
                end
            end
            sfa_pkg::S_MID: begin
                o_leaf_re    = 1'b1;
                o_leaf_raddr = mid_row32[ROW_AW-1:0];
                n_row        = mid_row32[ROW_AW-1:0];
                n_mid_word   = mid_word_m;
            end
            sfa_pkg::S_LEAF: begin
                // lowest free sits past the live count: nothing to grant
                if (grant32 < 32'(i_count)) begin
                    o_leaf_we     = 1'b1;
                    o_leaf_wdata  = leaf_set;
                    o_mid_we      = leaf_now_full;
                    o_mid_wdata   = mid_set;
                    n_res.granted = grant32[SW-1:0] + SW'(1);
                    n_res.status  = sfa_pkg::ST_OK;
                    if (leaf_now_full && mid_now_full) begin
                        n_top[r_mid_addr] = 1'b1;
                    end
                end
            end
            sfa_pkg::S_REL: begin
                if (rel_taken) begin
                    o_leaf_we         = 1'b1;
                    o_leaf_wdata      = i_leaf_rdata & ~rel_one;
                    o_mid_we          = 1'b1;
                    o_mid_wdata       = i_mid_rdata & ~row_one;
                    n_top[r_mid_addr] = 1'b0;
                    n_res.status      = sfa_pkg::ST_OK;
                end
            end
            sfa_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sfa_pkg::S_CLEAR;
            r_clr   <= '0;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid_addr <= n_mid_addr;
        r_row      <= n_row;
        r_bit      <= n_bit;
        r_mid_word <= n_mid_word;
        r_res      <= n_res;
    end

    assign o_ready     = (r_state == sfa_pkg::S_IDLE);
    assign o_res_valid = (r_state == sfa_pkg::S_DONE);
    assign o_res       = r_res;

endmodule

// ----- rtl/smallest_free_id_allocator.sv -----
// ----------------------------------------------------------------------------
// smallest_free_id_allocator
// Lowest free identifier allocator over a two-level bitmap held in RAM.
// ----------------------------------------------------------------------------
// Hands out identifiers 1..seat_count, lowest free first, and takes them back
// on release; each input transfer yields exactly one result transfer. After
// reset the block sweeps its bitmap RAM clear, one row per cycle, with
// s_tready low; the seat count register can be written during the sweep.
// Items are handled one at a time. From input transfer to result valid on
// the master side, a reserve goes through these steps: the summary flops
// pick a summary row, the summary RAM read picks a leaf row, the leaf RAM
// read picks the bit and the rows are written back, then the result moves
// to the output register. A release reads the leaf and summary rows
// together, then writes them, and a reserve with every row full or a
// release out of range goes straight to the output register. The dependent
// chain of RAM reads sets the pace of a reserve. One output register holds
// the result, so a new item is taken while the previous result waits.
// Reserve with nothing free returns status FULL; release of a free or
// out-of-range identifier returns BAD_RELEASE; neither changes the state.
// Lowering seat_count keeps the taken bits above the new count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smallest_free_id_allocator #(
    parameter int MAX_SEATS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [sfa_pkg::DATA_W-1:0]     i_s_tdata,   // [10:0] seat_number
    input  logic [0:0]                     i_s_tuser,   // [0] operation
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [sfa_pkg::DATA_W-1:0]     o_m_tdata,   // [10:0] granted_seat
    output logic [sfa_pkg::STATUS_W-1:0]   o_m_tuser,   // [1:0] status
    // seat count register
    input  logic                           i_cfg_we,
    input  logic [sfa_pkg::SEAT_W-1:0]     i_cfg_wdata
);

    localparam int ROWS   = (MAX_SEATS + sfa_pkg::WORD_W - 1) / sfa_pkg::WORD_W;
    localparam int MROWS  = (ROWS + sfa_pkg::WORD_W - 1) / sfa_pkg::WORD_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int MID_AW = (MROWS > 1) ? $clog2(MROWS) : 1;
    localparam logic [31:0] MAX_SEATS_U = 32'(MAX_SEATS);

    logic [sfa_pkg::SEAT_W-1:0] r_seat_count;
    logic [sfa_pkg::SEAT_W-1:0] eff_count;

    logic             r_out_valid, n_out_valid;
    sfa_pkg::t_result r_out, n_out;

    sfa_pkg::t_item   item;
    sfa_pkg::t_result res;
    logic             start, res_valid, out_free;

    logic              leaf_re, leaf_we, mid_re, mid_we;
    logic [ROW_AW-1:0] leaf_raddr, leaf_waddr;
    logic [MID_AW-1:0] mid_raddr, mid_waddr;
    sfa_pkg::t_word    leaf_rdata, leaf_wdata, mid_rdata, mid_wdata;

    // Seat count register, saturated to the bitmap size on use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_count <= sfa_pkg::SEAT_W'(1024);
        end else if (i_cfg_we) begin
            r_seat_count <= i_cfg_wdata;
        end
    end

    assign eff_count = (32'(r_seat_count) > MAX_SEATS_U) ?
                       MAX_SEATS_U[sfa_pkg::SEAT_W-1:0] : r_seat_count;

    assign item.op   = sfa_pkg::t_op'(i_s_tuser[0]);
    assign item.seat = i_s_tdata[sfa_pkg::SEAT_W-1:0];
    assign start     = i_s_tvalid && o_s_tready;

    // Output register: loaded when empty or draining this cycle.
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && out_free) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = sfa_pkg::DATA_W'(r_out.granted);
    assign o_m_tuser  = r_out.status;

    sfa_ctrl #(
        .MAX_SEATS (MAX_SEATS),
        .ROW_AW    (ROW_AW),
        .MID_AW    (MID_AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (item),
        .i_count      (eff_count),
        .i_out_free   (out_free),
        .o_ready      (o_s_tready),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_leaf_re    (leaf_re),
        .o_leaf_raddr (leaf_raddr),
        .i_leaf_rdata (leaf_rdata),
        .o_leaf_we    (leaf_we),
        .o_leaf_waddr (leaf_waddr),
        .o_leaf_wdata (leaf_wdata),
        .o_mid_re     (mid_re),
        .o_mid_raddr  (mid_raddr),
        .i_mid_rdata  (mid_rdata),
        .o_mid_we     (mid_we),
        .o_mid_waddr  (mid_waddr),
        .o_mid_wdata  (mid_wdata)
    );

    // Leaf bitmap: one taken bit per identifier, 32 to a row.
    sfa_ram #(
        .WIDTH (sfa_pkg::WORD_W),
        .DEPTH (ROWS),
        .AW    (ROW_AW)
    ) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_re    (leaf_re),
        .i_raddr (leaf_raddr),
        .o_rdata (leaf_rdata)
    );

    // Summary bitmap: one row-full bit per leaf row.
    sfa_ram #(
        .WIDTH (sfa_pkg::WORD_W),
        .DEPTH (MROWS),
        .AW    (MID_AW)
    ) u_mid_ram (
        .i_clk   (i_clk),
        .i_we    (mid_we),
        .i_waddr (mid_waddr),
        .i_wdata (mid_wdata),
        .i_re    (mid_re),
        .i_raddr (mid_raddr),
        .o_rdata (mid_rdata)
    );

endmodule

// ----- rtl/sfa_checker.sv -----
// ----------------------------------------------------------------------------
// sfa_checker
// Port-level checks for the lowest free identifier allocator, bound to top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "smallest_free_id_allocator_assert.svh"

module sfa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_s_tvalid,
    input logic                         o_s_tready,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [sfa_pkg::DATA_W-1:0]   o_m_tdata,
    input logic [sfa_pkg::STATUS_W-1:0] o_m_tuser
);

    // one item in flight: ready drops straight after a transfer
    `SFA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // any error result carries no identifier
    `SFA_ASSERT_SAME(a_err_no_grant, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != sfa_pkg::ST_OK), o_m_tdata == '0)

    // granted identifier fits the 11-bit field
    `SFA_ASSERT_SAME(a_pad_zero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[15:11] == 5'd0)

    // stalled result holds
    `SFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

endmodule

bind smallest_free_id_allocator sfa_checker u_sfa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
